>>> rtl/core/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg: shared types and constants for the RGB to HSV converter
// Fraction width, divider geometry and the hue sector code.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    // fraction bits of hue and saturation results
    localparam int FRAC_BITS = 16;

    // divider operand width: 6 * 255 needs 11 bits
    localparam int D_W = 11;
    // partial remainder stays below twice the divisor
    localparam int R_W = D_W + 1;
    // quotient keeps one integer bit and one extra bit for rounding
    localparam int Q_W = FRAC_BITS + 2;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = (Q_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // hue offset in sixths of a turn, set by the channel ordering
    typedef enum logic [1:0] {
        SECT_ZERO   = 2'd0,   // no swap
        SECT_NEG6   = 2'd1,   // green/blue swapped only
        SECT_NEG2   = 2'd2,   // red swapped only
        SECT_POS4   = 2'd3    // both swapped
    } sector_t;

    // data that rides alongside the dividers
    typedef struct packed {
        logic       hue_zero;
        logic       sat_zero;
        logic [7:0] value;
        logic [7:0] alpha;
    } side_t;

endpackage

>>> rtl/core/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: 8-bit RGBA pixel to HSV
// Sorts the color channels, forms chroma and the hue numerator, then divides
// in two pipelined dividers to get hue and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: red, green, blue, alpha with pixel_valid / pixel_stall.
//   Result channel: hue, saturation, value_level, alpha_out with
//   hsv_valid / hsv_stall. A transfer happens on a clock edge with valid
//   high and stall low.
//   Throughput is one pixel per clock while pixel_stall is low. The
//   pipeline registers are: sort, chroma, numerator, nine divider stages
//   at two quotient bits each, and the output register.
//   The whole pipeline moves as one; when the result register holds a pixel
//   and hsv_stall is high, every stage holds and pixel_stall goes high, so
//   nothing is dropped or repeated. Bubbles stay in place during a stall.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    output logic        hsv_valid,
    input  logic        hsv_stall,
    output logic [15:0] hue,
    output logic [15:0] saturation,
    output logic [7:0]  value_level,
    output logic [7:0]  alpha_out
);

    logic advance;

    // stage 1: ordered channels
    logic                  s1_valid_reg;
    logic [7:0]            s1_c0_reg, s1_c1_reg, s1_c2_reg, s1_alpha_reg;
    rgbhsv_pkg::sector_t   s1_sect_reg;
    logic [7:0]            s1_c0_next, s1_c1_next, s1_c2_next;
    rgbhsv_pkg::sector_t   s1_sect_next;

    // stage 2: chroma and channel difference
    logic                  s2_valid_reg;
    logic [7:0]            s2_chroma_reg, s2_c0_reg, s2_alpha_reg;
    logic [8:0]            s2_diff_reg;
    rgbhsv_pkg::sector_t   s2_sect_reg;
    logic [7:0]            s2_chroma_next;
    logic [8:0]            s2_diff_next;

    // stage 3: divider operands
    logic                         s3_valid_reg;
    logic [rgbhsv_pkg::D_W-1:0]   s3_hnum_reg, s3_hden_reg, s3_snum_reg, s3_sden_reg;
    rgbhsv_pkg::side_t            s3_side_reg;
    logic [rgbhsv_pkg::D_W:0]     s3_hnum_next;
    logic [rgbhsv_pkg::D_W:0]     chroma_w, diff_w;

    // divider stages
    logic                         div_valid_reg [rgbhsv_pkg::DIV_STAGES];
    rgbhsv_pkg::side_t            side_reg [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::Q_W-1:0]   hue_quo, sat_quo;
    logic [rgbhsv_pkg::Q_W-1:0]   hue_rnd, sat_rnd;
    rgbhsv_pkg::side_t            side_last;

    // output
    logic        out_valid_reg;
    logic [15:0] hue_reg, sat_reg, hue_next, sat_next;
    logic [7:0]  value_reg, alpha_reg;

    assign advance     = !out_valid_reg || !hsv_stall;
    assign pixel_stall = !advance;

    // ---------------- stage 1: two conditional swaps ----------------
    always_comb
    begin
        logic [7:0] hi_gb;
        logic [7:0] lo_gb;
        logic       swap_gb;
        logic       swap_r;
        swap_gb = green < blue;
        hi_gb   = swap_gb ? blue : green;
        lo_gb   = swap_gb ? green : blue;
        swap_r  = red < hi_gb;
        s1_c0_next = swap_r ? hi_gb : red;
        s1_c1_next = swap_r ? red : hi_gb;
        s1_c2_next = lo_gb;
        case ({swap_r, swap_gb})
            2'b00:   s1_sect_next = rgbhsv_pkg::SECT_ZERO;
            2'b01:   s1_sect_next = rgbhsv_pkg::SECT_NEG6;
            2'b10:   s1_sect_next = rgbhsv_pkg::SECT_NEG2;
            2'b11:   s1_sect_next = rgbhsv_pkg::SECT_POS4;
            default: s1_sect_next = rgbhsv_pkg::SECT_ZERO;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_c0_reg    <= s1_c0_next;
            s1_c1_reg    <= s1_c1_next;
            s1_c2_reg    <= s1_c2_next;
            s1_sect_reg  <= s1_sect_next;
            s1_alpha_reg <= alpha;
        end
    end

    // ---------------- stage 2: chroma ----------------
    always_comb
    begin
        logic [7:0] lo;
        lo             = (s1_c1_reg < s1_c2_reg) ? s1_c1_reg : s1_c2_reg;
        s2_chroma_next = s1_c0_reg - lo;
        s2_diff_next   = {1'b0, s1_c1_reg} - {1'b0, s1_c2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_chroma_reg <= s2_chroma_next;
            s2_diff_reg   <= s2_diff_next;
            s2_sect_reg   <= s1_sect_reg;
            s2_c0_reg     <= s1_c0_reg;
            s2_alpha_reg  <= s1_alpha_reg;
        end
    end

    // ---------------- stage 3: |K*C + d| and 6*C ----------------
    // every sector gives a result in 0..6C, so modular arithmetic is exact
    assign chroma_w = {{(rgbhsv_pkg::D_W-7){1'b0}}, s2_chroma_reg};
    assign diff_w   = {{(rgbhsv_pkg::D_W-8){s2_diff_reg[8]}}, s2_diff_reg};

    always_comb
    begin
        case (s2_sect_reg)
            rgbhsv_pkg::SECT_ZERO: s3_hnum_next = diff_w;
            rgbhsv_pkg::SECT_NEG6: s3_hnum_next = (chroma_w << 2) + (chroma_w << 1) - diff_w;
            rgbhsv_pkg::SECT_NEG2: s3_hnum_next = (chroma_w << 1) - diff_w;
            rgbhsv_pkg::SECT_POS4: s3_hnum_next = (chroma_w << 2) + diff_w;
            default:               s3_hnum_next = diff_w;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_hnum_reg <= s3_hnum_next[rgbhsv_pkg::D_W-1:0];
            s3_hden_reg <= chroma_w[rgbhsv_pkg::D_W-1:0] * 3'd6;
            s3_snum_reg <= chroma_w[rgbhsv_pkg::D_W-1:0];
            s3_sden_reg <= {{(rgbhsv_pkg::D_W-8){1'b0}}, s2_c0_reg};
            s3_side_reg.hue_zero <= (s2_chroma_reg == 8'd0);
            s3_side_reg.sat_zero <= (s2_c0_reg == 8'd0);
            s3_side_reg.value    <= s2_c0_reg;
            s3_side_reg.alpha    <= s2_alpha_reg;
        end
    end

    // ---------------- dividers ----------------
    rgbhsv_div u_hue_div (
        .clk     (clk),
        .advance (advance),
        .num     (s3_hnum_reg),
        .den     (s3_hden_reg),
        .quo     (hue_quo)
    );

    rgbhsv_div u_sat_div (
        .clk     (clk),
        .advance (advance),
        .num     (s3_snum_reg),
        .den     (s3_sden_reg),
        .quo     (sat_quo)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < rgbhsv_pkg::DIV_STAGES; i++)
            begin
                if (i == 0)
                begin
                    side_reg[i] <= s3_side_reg;
                end
                else
                begin
                    side_reg[i] <= side_reg[i-1];
                end
            end
        end
    end

    assign side_last = side_reg[rgbhsv_pkg::DIV_STAGES-1];

    // ---------------- output: round half up, wrap / clamp ----------------
    assign hue_rnd = hue_quo + 1'b1;
    assign sat_rnd = sat_quo + 1'b1;

    always_comb
    begin
        if (side_last.hue_zero)
        begin
            hue_next = '0;
        end
        else
        begin
            hue_next = hue_rnd[rgbhsv_pkg::FRAC_BITS:1];
        end

        if (side_last.sat_zero)
        begin
            sat_next = '0;
        end
        else if (sat_rnd[rgbhsv_pkg::FRAC_BITS+1])
        begin
            sat_next = '1;
        end
        else
        begin
            sat_next = sat_rnd[rgbhsv_pkg::FRAC_BITS:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= side_last.value;
            alpha_reg <= side_last.alpha;
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < rgbhsv_pkg::DIV_STAGES; i++)
            begin
                div_valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            s1_valid_reg <= pixel_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            for (int i = 0; i < rgbhsv_pkg::DIV_STAGES; i++)
            begin
                if (i == 0)
                begin
                    div_valid_reg[i] <= s3_valid_reg;
                end
                else
                begin
                    div_valid_reg[i] <= div_valid_reg[i-1];
                end
            end
            out_valid_reg <= div_valid_reg[rgbhsv_pkg::DIV_STAGES-1];
        end
    end

    assign hsv_valid   = out_valid_reg;
    assign hue         = hue_reg;
    assign saturation  = sat_reg;
    assign value_level = value_reg;
    assign alpha_out   = alpha_reg;

endmodule

>>> rtl/core/rgbhsv_div.sv
// ----------------------------------------------------------------------------
// rgbhsv_div: pipelined restoring divider
// Gives floor(num * 2^(Q_W-1) / den) for num <= den, a fixed number of
// quotient bits per register stage. Advances only when enabled.
// ----------------------------------------------------------------------------
module rgbhsv_div (
    input  logic                         clk,
    input  logic                         advance,
    input  logic [rgbhsv_pkg::D_W-1:0]   num,
    input  logic [rgbhsv_pkg::D_W-1:0]   den,
    output logic [rgbhsv_pkg::Q_W-1:0]   quo
);

    logic [rgbhsv_pkg::R_W-1:0] rem_reg [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::Q_W-1:0] quo_reg [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::D_W-1:0] den_reg [rgbhsv_pkg::DIV_STAGES];

    genvar gi;
    generate
        for (gi = 0; gi < rgbhsv_pkg::DIV_STAGES; gi++)
        begin : g_stage
            logic [rgbhsv_pkg::R_W-1:0] rem_in;
            logic [rgbhsv_pkg::Q_W-1:0] quo_in;
            logic [rgbhsv_pkg::D_W-1:0] den_in;
            logic [rgbhsv_pkg::R_W-1:0] rem_next;
            logic [rgbhsv_pkg::Q_W-1:0] quo_next;

            if (gi == 0)
            begin : g_first
                assign rem_in = {1'b0, num};
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[gi-1];
                assign quo_in = quo_reg[gi-1];
                assign den_in = den_reg[gi-1];
            end

            // after the first stage the remainder arrives already doubled; compare, subtract, shift
            always_comb
            begin
                rem_next = rem_in;
                quo_next = quo_in;
                for (int s = 0; s < rgbhsv_pkg::STEPS_PER_STAGE; s++)
                begin
                    if (rem_next >= {1'b0, den_in})
                    begin
                        rem_next = rem_next - {1'b0, den_in};
                        quo_next = {quo_next[rgbhsv_pkg::Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next = {quo_next[rgbhsv_pkg::Q_W-2:0], 1'b0};
                    end
                    rem_next = {rem_next[rgbhsv_pkg::R_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[gi] <= rem_next;
                    quo_reg[gi] <= quo_next;
                    den_reg[gi] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[rgbhsv_pkg::DIV_STAGES-1];

endmodule
